FILE: rtl/one_wire_bus_master_macros.svh
// assertion macros shared by the 1-wire bus master rtl
// expects signals named clk and rst_n in the scope that uses them
`ifndef ONE_WIRE_BUS_MASTER_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define OWBM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define OWBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/owbm_pkg.sv
// shared constants and types for the 1-wire bus master
// no dependencies
package owbm_pkg;

    // field widths
    localparam int unsigned MODE_W = 3;
    localparam int unsigned DATA_W = 8;
    localparam int unsigned CFG_W  = 10;
    localparam int unsigned CIDX_W = 3;

    // item modes
    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RESET   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WR_BYTE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RD_BYTE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WR_BIT  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RD_BIT  = 3'd5;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_RESET_LOW    = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_RESET_REC    = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_SLOT_LOW     = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_READ_SAMPLE  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_READ_REC     = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_WRITE_HOLD   = 3'd6;

    // timing register reset values, in ticks
    localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd400;
    localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 10'd50;
    localparam logic [CFG_W-1:0] RST_RESET_REC     = 10'd100;
    localparam logic [CFG_W-1:0] RST_SLOT_LOW      = 10'd1;
    localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 10'd14;
    localparam logic [CFG_W-1:0] RST_READ_REC      = 10'd40;
    localparam logic [CFG_W-1:0] RST_WRITE_HOLD    = 10'd55;

    // slot timing register set
    typedef struct packed {
        logic [CFG_W-1:0] reset_low_time;
        logic [CFG_W-1:0] presence_wait_time;
        logic [CFG_W-1:0] reset_recovery_time;
        logic [CFG_W-1:0] slot_low_time;
        logic [CFG_W-1:0] read_sample_time;
        logic [CFG_W-1:0] read_recovery_time;
        logic [CFG_W-1:0] write_hold_time;
    } timing_t;

endpackage

FILE: rtl/owbm_if.sv
// valid/ready channel interfaces for the 1-wire bus master
// depends on owbm_pkg
interface owbm_in_if;
    logic                         valid;
    logic                         ready;
    logic [owbm_pkg::MODE_W-1:0]  mode;
    logic [owbm_pkg::DATA_W-1:0]  data_byte;
    logic                         line_level;

    modport source (output valid, output mode, output data_byte, output line_level,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input line_level,
                    output ready);
endinterface

interface owbm_out_if;
    logic                         valid;
    logic                         ready;
    logic                         drive_low;
    logic                         busy_res;
    logic                         done_res;
    logic [owbm_pkg::DATA_W-1:0]  read_data;
    logic                         presence_level;
    logic                         rejected;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output read_data, output presence_level, output rejected,
                    input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input read_data, input presence_level, input rejected,
                    output ready);
endinterface

FILE: rtl/one_wire_bus_master.sv
// 1-wire bus master: one item in, one result out, every cycle. Each accepted item
// (a tick carrying the sampled line level, or a command) updates the phase,
// counter and shift register, and its result is registered; the block takes one
// item per clock, limited only by the one-deep result register,
// which still accepts a new item in the cycle its result is transferred out.
// Depends on owbm_pkg, owbm_if.sv and one_wire_bus_master_macros.svh.
`include "one_wire_bus_master_macros.svh"

module one_wire_bus_master (
    input  logic                          clk,
    input  logic                          rst_n,
    owbm_in_if.sink                       item,
    owbm_out_if.source                    result,
    input  logic                          cfg_we,
    input  logic [owbm_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [owbm_pkg::CFG_W-1:0]    cfg_data
);

    // phase codes
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RST_LOW  = 3'd1;
    localparam logic [2:0] PH_RST_WAIT = 3'd2;
    localparam logic [2:0] PH_RST_REC  = 3'd3;
    localparam logic [2:0] PH_SLOT_LOW = 3'd4;
    localparam logic [2:0] PH_RD_WAIT  = 3'd5;
    localparam logic [2:0] PH_RD_REC   = 3'd6;
    localparam logic [2:0] PH_WR_HOLD  = 3'd7;

    localparam int unsigned CW = owbm_pkg::CFG_W;
    localparam int unsigned DW = owbm_pkg::DATA_W;

    owbm_pkg::timing_t  timing_reg;

    logic [2:0]         phase_reg, phase_next;
    logic [2:0]         operation_reg, operation_next;
    logic [CW-1:0]      tick_count_reg, tick_count_next;
    logic [3:0]         bits_left_reg, bits_left_next;
    logic [DW-1:0]      shift_data_reg, shift_data_next;
    logic               presence_seen_reg, presence_seen_next;
    logic               driving_low_reg, driving_low_next;

    logic               res_valid_reg;
    logic               res_done_reg, res_rej_reg;
    logic [DW-1:0]      res_data_reg;

    logic               accept;
    logic [CW-1:0]      limit;
    logic [CW:0]        count_inc;
    logic               expire;
    logic               slot_end;
    logic               done;
    logic               rej;
    logic               read_op;
    logic [DW-1:0]      rd_data;

    // handshake: the result register frees up in the cycle it is transferred
    assign item.ready = !res_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.reset_low_time      <= owbm_pkg::RST_RESET_LOW;
            timing_reg.presence_wait_time  <= owbm_pkg::RST_PRESENCE_WAIT;
            timing_reg.reset_recovery_time <= owbm_pkg::RST_RESET_REC;
            timing_reg.slot_low_time       <= owbm_pkg::RST_SLOT_LOW;
            timing_reg.read_sample_time    <= owbm_pkg::RST_READ_SAMPLE;
            timing_reg.read_recovery_time  <= owbm_pkg::RST_READ_REC;
            timing_reg.write_hold_time     <= owbm_pkg::RST_WRITE_HOLD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                owbm_pkg::CFG_RESET_LOW:     timing_reg.reset_low_time      <= cfg_data;
                owbm_pkg::CFG_PRESENCE_WAIT: timing_reg.presence_wait_time  <= cfg_data;
                owbm_pkg::CFG_RESET_REC:     timing_reg.reset_recovery_time <= cfg_data;
                owbm_pkg::CFG_SLOT_LOW:      timing_reg.slot_low_time       <= cfg_data;
                owbm_pkg::CFG_READ_SAMPLE:   timing_reg.read_sample_time    <= cfg_data;
                owbm_pkg::CFG_READ_REC:      timing_reg.read_recovery_time  <= cfg_data;
                owbm_pkg::CFG_WRITE_HOLD:    timing_reg.write_hold_time     <= cfg_data;
                default: ;
            endcase
        end
    end

    // phase length select
    always_comb
    begin
        case (phase_reg)
            PH_RST_LOW:  limit = timing_reg.reset_low_time;
            PH_RST_WAIT: limit = timing_reg.presence_wait_time;
            PH_RST_REC:  limit = timing_reg.reset_recovery_time;
            PH_SLOT_LOW: limit = timing_reg.slot_low_time;
            PH_RD_WAIT:  limit = timing_reg.read_sample_time;
            PH_RD_REC:   limit = timing_reg.read_recovery_time;
            PH_WR_HOLD:  limit = timing_reg.write_hold_time;
            default:     limit = '0;
        endcase
    end

    // a zero limit behaves like one since the incremented count is at least one
    assign count_inc = {1'b0, tick_count_reg} + {{CW{1'b0}}, 1'b1};
    assign expire    = count_inc >= {1'b0, limit};
    assign read_op   = (operation_reg == owbm_pkg::MODE_RD_BYTE)
                    || (operation_reg == owbm_pkg::MODE_RD_BIT);

    // next-state logic for one item
    always_comb
    begin
        phase_next         = phase_reg;
        operation_next     = operation_reg;
        tick_count_next    = tick_count_reg;
        bits_left_next     = bits_left_reg;
        shift_data_next    = shift_data_reg;
        presence_seen_next = presence_seen_reg;
        driving_low_next   = driving_low_reg;
        slot_end           = 1'b0;
        done               = 1'b0;
        rej                = 1'b0;

        if (accept)
        begin
            if (item.mode == owbm_pkg::MODE_TICK)
            begin
                // tick: advance the running phase
                if (phase_reg != PH_IDLE)
                    tick_count_next = expire ? '0 : count_inc[CW-1:0];
                case (phase_reg)
                    PH_RST_LOW:
                        if (expire)
                        begin
                            driving_low_next = 1'b0;
                            phase_next       = PH_RST_WAIT;
                        end
                    PH_RST_WAIT:
                        if (expire)
                        begin
                            presence_seen_next = item.line_level;
                            phase_next         = PH_RST_REC;
                        end
                    PH_RST_REC:
                        if (expire)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    PH_SLOT_LOW:
                        if (expire)
                        begin
                            if (read_op)
                            begin
                                driving_low_next = 1'b0;
                                phase_next       = PH_RD_WAIT;
                            end
                            else
                            begin
                                if (shift_data_reg[0])
                                    driving_low_next = 1'b0;
                                phase_next = PH_WR_HOLD;
                            end
                        end
                    PH_RD_WAIT:
                        if (expire)
                        begin
                            if (operation_reg == owbm_pkg::MODE_RD_BIT)
                                shift_data_next = {{(DW-1){1'b0}}, item.line_level};
                            else
                                shift_data_next = {item.line_level, shift_data_reg[DW-1:1]};
                            phase_next = PH_RD_REC;
                        end
                    PH_RD_REC:
                        if (expire)
                            slot_end = 1'b1;
                    PH_WR_HOLD:
                        if (expire)
                        begin
                            driving_low_next = 1'b0;
                            shift_data_next  = {1'b0, shift_data_reg[DW-1:1]};
                            slot_end         = 1'b1;
                        end
                    default: ;
                endcase

                // end of a bit slot: next slot or operation complete
                if (slot_end)
                begin
                    bits_left_next = bits_left_reg - 4'd1;
                    if (bits_left_next != 4'd0)
                    begin
                        driving_low_next = 1'b1;
                        phase_next       = PH_SLOT_LOW;
                        tick_count_next  = '0;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
            end
            else if (item.mode <= owbm_pkg::MODE_RD_BIT)
            begin
                // command: start when idle, else reject
                if (phase_reg != PH_IDLE)
                    rej = 1'b1;
                else
                begin
                    operation_next   = item.mode;
                    tick_count_next  = '0;
                    driving_low_next = 1'b1;
                    if (item.mode == owbm_pkg::MODE_RESET)
                        phase_next = PH_RST_LOW;
                    else
                    begin
                        phase_next = PH_SLOT_LOW;
                        if (item.mode == owbm_pkg::MODE_WR_BYTE)
                        begin
                            shift_data_next = item.data_byte;
                            bits_left_next  = 4'd8;
                        end
                        else if (item.mode == owbm_pkg::MODE_WR_BIT)
                        begin
                            shift_data_next = {{(DW-1){1'b0}}, item.data_byte[0]};
                            bits_left_next  = 4'd1;
                        end
                        else if (item.mode == owbm_pkg::MODE_RD_BYTE)
                        begin
                            shift_data_next = '0;
                            bits_left_next  = 4'd8;
                        end
                        else
                        begin
                            shift_data_next = '0;
                            bits_left_next  = 4'd1;
                        end
                    end
                end
            end
        end
    end

    // read byte only shows on the completion of a read
    assign rd_data = (done && read_op) ? shift_data_next : '0;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            operation_reg     <= '0;
            tick_count_reg    <= '0;
            bits_left_reg     <= '0;
            shift_data_reg    <= '0;
            presence_seen_reg <= 1'b1;
            driving_low_reg   <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            operation_reg     <= operation_next;
            tick_count_reg    <= tick_count_next;
            bits_left_reg     <= bits_left_next;
            shift_data_reg    <= shift_data_next;
            presence_seen_reg <= presence_seen_next;
            driving_low_reg   <= driving_low_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    // result payload, loaded on each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_done_reg <= done;
            res_rej_reg  <= rej;
            res_data_reg <= rd_data;
        end
    end

    // drive, busy and presence follow the state that the last item left
    assign result.valid          = res_valid_reg;
    assign result.drive_low      = driving_low_reg;
    assign result.busy_res       = (phase_reg != PH_IDLE);
    assign result.done_res       = res_done_reg;
    assign result.read_data      = res_data_reg;
    assign result.presence_level = presence_seen_reg;
    assign result.rejected       = res_rej_reg;

    // checks on the master's own logic
    `OWBM_ASSERT_IMPLY(a_done_not_busy, res_valid_reg && res_done_reg,
        phase_reg == PH_IDLE, "completion reported while still busy")
    `OWBM_ASSERT_IMPLY(a_reject_busy, res_valid_reg && res_rej_reg,
        phase_reg != PH_IDLE, "command rejected while idle")
    `OWBM_ASSERT_IMPLY(a_idle_released, phase_reg == PH_IDLE,
        !driving_low_reg && bits_left_reg == 4'd0, "idle bus left driven or slots pending")
    `OWBM_ASSERT_IMPLY(a_data_at_done, res_valid_reg && res_data_reg != '0,
        res_done_reg, "read data shown outside a completion")
    `OWBM_ASSERT_NEXT(a_result_held, res_valid_reg && !result.ready,
        res_valid_reg, "result dropped before transfer")

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the one-wire bus master: directed table, then random traffic
// predicts every result with a cycle-free model of the master kept in this module
// depends on owbm_pkg, owbm_if.sv and the one_wire_bus_master rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned  CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned  SHOW_LIMIT   = 10;
    localparam int unsigned  BURST_ITEMS  = 325;
    localparam int unsigned  NUM_SETTINGS = 6;
    localparam int unsigned  NUM_REGS     = 7;
    localparam int unsigned  PLAN_LEN     = 29;
    localparam logic [owbm_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [owbm_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd7;
    localparam logic [owbm_pkg::CIDX_W-1:0] CFG_UNUSED   = 3'd7;
    localparam logic [owbm_pkg::CFG_W-1:0]  MAX_TICKS    = 10'h3FF;
    localparam logic [3:0]                  BYTE_BITS    = 4'd8;

    // model phase codes
    localparam logic [2:0] BUS_IDLE = 3'd0;
    localparam logic [2:0] RST_LOW  = 3'd1;
    localparam logic [2:0] RST_WAIT = 3'd2;
    localparam logic [2:0] RST_REC  = 3'd3;
    localparam logic [2:0] SLOT_LOW = 3'd4;
    localparam logic [2:0] RD_WAIT  = 3'd5;
    localparam logic [2:0] RD_REC   = 3'd6;
    localparam logic [2:0] WR_HOLD  = 3'd7;

    typedef struct packed {
        logic [owbm_pkg::MODE_W-1:0] mode;
        logic [owbm_pkg::DATA_W-1:0] data_byte;
        logic                        line_level;
    } bus_item_t;

    typedef struct packed {
        logic                        drive_low;
        logic                        busy_res;
        logic                        done_res;
        logic [owbm_pkg::DATA_W-1:0] read_data;
        logic                        presence_level;
        logic                        rejected;
    } bus_status_t;

    typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        logic [owbm_pkg::MODE_W-1:0] mode;
        logic [owbm_pkg::DATA_W-1:0] data_byte;
        logic                        line_level;
        logic [15:0]                 reps;
        logic [owbm_pkg::CIDX_W-1:0] reg_idx;
        logic [owbm_pkg::CFG_W-1:0]  reg_val;
        logic                        typed;
        bus_status_t                 want;
    } plan_row_t;

    localparam bus_status_t ST_IDLE = '{drive_low: 1'b0, busy_res: 1'b0, done_res: 1'b0,
        read_data: 8'h00, presence_level: 1'b1, rejected: 1'b0};
    localparam bus_status_t ST_RESET_START = '{drive_low: 1'b1, busy_res: 1'b1,
        done_res: 1'b0, read_data: 8'h00, presence_level: 1'b1, rejected: 1'b0};
    localparam bus_status_t ST_TURNED_AWAY = '{drive_low: 1'b1, busy_res: 1'b1,
        done_res: 1'b0, read_data: 8'h00, presence_level: 1'b1, rejected: 1'b1};
    localparam bus_status_t ST_NONE = '0;

    localparam logic [owbm_pkg::CIDX_W-1:0] REG_ORDER [NUM_REGS] = '{
        owbm_pkg::CFG_RESET_LOW, owbm_pkg::CFG_PRESENCE_WAIT, owbm_pkg::CFG_RESET_REC,
        owbm_pkg::CFG_SLOT_LOW, owbm_pkg::CFG_READ_SAMPLE, owbm_pkg::CFG_READ_REC,
        owbm_pkg::CFG_WRITE_HOLD};
    localparam logic [owbm_pkg::CFG_W-1:0] REG_DEFAULTS [NUM_REGS] = '{
        owbm_pkg::RST_RESET_LOW, owbm_pkg::RST_PRESENCE_WAIT, owbm_pkg::RST_RESET_REC,
        owbm_pkg::RST_SLOT_LOW, owbm_pkg::RST_READ_SAMPLE, owbm_pkg::RST_READ_REC,
        owbm_pkg::RST_WRITE_HOLD};

    // directed table: idle behavior, short timings, every command, rejection, mid-phase change
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{ROW_ITEM, owbm_pkg::MODE_TICK, 8'h00, 1'b1, 16'd1, CFG_UNUSED, 10'd0, 1'b1,
          ST_IDLE},
        '{ROW_ITEM, MODE_SPARE_A, 8'hFF, 1'b0, 16'd1, CFG_UNUSED, 10'd0, 1'b1, ST_IDLE},
        '{ROW_ITEM, MODE_SPARE_B, 8'h00, 1'b1, 16'd1, CFG_UNUSED, 10'd0, 1'b1, ST_IDLE},
        '{ROW_REG, owbm_pkg::MODE_TICK, 8'h00, 1'b1, 16'd0,
          owbm_pkg::CFG_RESET_LOW, 10'd2, 1'b0, ST_NONE},
        '{ROW_REG, owbm_pkg::MODE_TICK, 8'h00, 1'b1, 16'd0,
          owbm_pkg::CFG_PRESENCE_WAIT, 10'd0, 1'b0, ST_NONE},
        '{ROW_REG, owbm_pkg::MODE_TICK, 8'h00, 1'b1, 16'd0,
          owbm_pkg::CFG_RESET_REC, 10'd1, 1'b0, ST_NONE},
        '{ROW_REG, owbm_pkg::MODE_TICK, 8'h00, 1'b1, 16'd0,
          owbm_pkg::CFG_SLOT_LOW, 10'd0, 1'b0, ST_NONE},
        '{ROW_REG, owbm_pkg::MODE_TICK, 8'h00, 1'b1, 16'd0,
          owbm_pkg::CFG_READ_SAMPLE, 10'd1, 1'b0, ST_NONE},
        '{ROW_REG, owbm_pkg::MODE_TICK, 8'h00, 1'b1, 16'd0,
          owbm_pkg::CFG_READ_REC, 10'd1, 1'b0, ST_NONE},
        '{ROW_REG, owbm_pkg::MODE_TICK, 8'h00, 1'b1, 16'd0,
          owbm_pkg::CFG_WRITE_HOLD, 10'd1, 1'b0, ST_NONE},
        '{ROW_REG, owbm_pkg::MODE_TICK, 8'h00, 1'b1, 16'd0,
          CFG_UNUSED, MAX_TICKS, 1'b0, ST_NONE},
        '{ROW_ITEM, owbm_pkg::MODE_RESET, 8'h00, 1'b1, 16'd1, CFG_UNUSED, 10'd0, 1'b1,
          ST_RESET_START},
        '{ROW_ITEM, owbm_pkg::MODE_WR_BYTE, 8'hFF, 1'b1, 16'd1, CFG_UNUSED, 10'd0, 1'b1,
          ST_TURNED_AWAY},
        '{ROW_ITEM, owbm_pkg::MODE_TICK, 8'h00, 1'b0, 16'd4, CFG_UNUSED, 10'd0, 1'b0,
          ST_NONE},
        '{ROW_ITEM, owbm_pkg::MODE_WR_BYTE, 8'h00, 1'b0, 16'd1, CFG_UNUSED, 10'd0, 1'b0,
          ST_NONE},
        '{ROW_ITEM, owbm_pkg::MODE_TICK, 8'h00, 1'b1, 16'd16, CFG_UNUSED, 10'd0, 1'b0,
          ST_NONE},
        '{ROW_ITEM, owbm_pkg::MODE_WR_BYTE, 8'hFF, 1'b0, 16'd1, CFG_UNUSED, 10'd0, 1'b0,
          ST_NONE},
        '{ROW_ITEM, owbm_pkg::MODE_TICK, 8'hFF, 1'b1, 16'd16, CFG_UNUSED, 10'd0, 1'b0,
          ST_NONE},
        '{ROW_ITEM, owbm_pkg::MODE_RD_BYTE, 8'h5A, 1'b0, 16'd1, CFG_UNUSED, 10'd0, 1'b0,
          ST_NONE},
        '{ROW_ITEM, owbm_pkg::MODE_TICK, 8'h00, 1'b1, 16'd24, CFG_UNUSED, 10'd0, 1'b0,
          ST_NONE},
        '{ROW_ITEM, owbm_pkg::MODE_WR_BIT, 8'hFE, 1'b1, 16'd1, CFG_UNUSED, 10'd0, 1'b0,
          ST_NONE},
        '{ROW_ITEM, owbm_pkg::MODE_TICK, 8'h00, 1'b1, 16'd2, CFG_UNUSED, 10'd0, 1'b0,
          ST_NONE},
        '{ROW_ITEM, owbm_pkg::MODE_RD_BIT, 8'hFF, 1'b1, 16'd1, CFG_UNUSED, 10'd0, 1'b0,
          ST_NONE},
        '{ROW_ITEM, owbm_pkg::MODE_TICK, 8'h00, 1'b0, 16'd3, CFG_UNUSED, 10'd0, 1'b0,
          ST_NONE},
        '{ROW_REG, owbm_pkg::MODE_TICK, 8'h00, 1'b1, 16'd0,
          owbm_pkg::CFG_RESET_LOW, MAX_TICKS, 1'b0, ST_NONE},
        '{ROW_ITEM, owbm_pkg::MODE_RESET, 8'h00, 1'b1, 16'd1, CFG_UNUSED, 10'd0, 1'b0,
          ST_NONE},
        '{ROW_ITEM, owbm_pkg::MODE_TICK, 8'h00, 1'b1, 16'd5, CFG_UNUSED, 10'd0, 1'b0,
          ST_NONE},
        '{ROW_REG, owbm_pkg::MODE_TICK, 8'h00, 1'b1, 16'd0,
          owbm_pkg::CFG_RESET_LOW, 10'd1, 1'b0, ST_NONE},
        '{ROW_ITEM, owbm_pkg::MODE_TICK, 8'h00, 1'b1, 16'd3, CFG_UNUSED, 10'd0, 1'b0,
          ST_NONE}
    };

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [owbm_pkg::CIDX_W-1:0] cfg_index;
    logic [owbm_pkg::CFG_W-1:0]  cfg_data;

    owbm_in_if  item_ch ();
    owbm_out_if result_ch ();

    one_wire_bus_master u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // master model state and timing registers
    owbm_pkg::timing_t           t_cfg;
    logic [2:0]                  m_phase;
    logic [owbm_pkg::MODE_W-1:0] m_op;
    logic [owbm_pkg::CFG_W-1:0]  m_count;
    logic [3:0]                  m_bits;
    logic [7:0]                  m_shift;
    logic                        m_presence;
    logic                        m_low;

    bus_status_t pending_status [$];

    int unsigned cycle_count = 0;
    int unsigned src_idle_pct = 22;
    int unsigned snk_idle_pct = 80;
    int unsigned mismatch_count = 0;
    int unsigned results_checked = 0;
    int unsigned transfers_in = 0;
    int unsigned ops_started = 0;
    int unsigned commands_turned_away = 0;
    int unsigned reg_writes = 0;

    // clock and cycle counter
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d results still outstanding",
                 cycle_count, pending_status.size());
        $display("FAILURE");
        $finish;
    end

    function automatic void reset_model();
        t_cfg = '{owbm_pkg::RST_RESET_LOW, owbm_pkg::RST_PRESENCE_WAIT,
                  owbm_pkg::RST_RESET_REC, owbm_pkg::RST_SLOT_LOW,
                  owbm_pkg::RST_READ_SAMPLE, owbm_pkg::RST_READ_REC,
                  owbm_pkg::RST_WRITE_HOLD};
        m_phase    = BUS_IDLE;
        m_op       = owbm_pkg::MODE_TICK;
        m_count    = '0;
        m_bits     = '0;
        m_shift    = '0;
        m_presence = 1'b1;
        m_low      = 1'b0;
    endfunction

    // count one tick of the current phase; true when the phase is over
    function automatic bit tick_elapsed(input logic [owbm_pkg::CFG_W-1:0] limit);
        logic [owbm_pkg::CFG_W:0] nxt;
        nxt = {1'b0, m_count} + 1'b1;
        if (nxt >= {1'b0, limit})
        begin
            m_count = '0;
            return 1'b1;
        end
        m_count = nxt[owbm_pkg::CFG_W-1:0];
        return 1'b0;
    endfunction

    function automatic bit reading();
        return (m_op == owbm_pkg::MODE_RD_BYTE) || (m_op == owbm_pkg::MODE_RD_BIT);
    endfunction

    function automatic void start_slot();
        m_low   = 1'b1;
        m_phase = SLOT_LOW;
        m_count = '0;
    endfunction

    // one bit slot over; true when the whole command is finished
    function automatic bit finish_slot();
        m_bits = m_bits - 1'b1;
        if (m_bits != 0)
        begin
            start_slot();
            return 1'b0;
        end
        m_phase = BUS_IDLE;
        return 1'b1;
    endfunction

    function automatic bit tick_bus(input logic level);
        case (m_phase)
            RST_LOW:
                if (tick_elapsed(t_cfg.reset_low_time))
                begin
                    m_low   = 1'b0;
                    m_phase = RST_WAIT;
                end
            RST_WAIT:
                if (tick_elapsed(t_cfg.presence_wait_time))
                begin
                    m_presence = level;
                    m_phase    = RST_REC;
                end
            RST_REC:
                if (tick_elapsed(t_cfg.reset_recovery_time))
                begin
                    m_phase = BUS_IDLE;
                    return 1'b1;
                end
            SLOT_LOW:
                if (tick_elapsed(t_cfg.slot_low_time))
                begin
                    if (reading())
                    begin
                        m_low   = 1'b0;
                        m_phase = RD_WAIT;
                    end
                    else
                    begin
                        if (m_shift[0])
                            m_low = 1'b0;
                        m_phase = WR_HOLD;
                    end
                end
            RD_WAIT:
                if (tick_elapsed(t_cfg.read_sample_time))
                begin
                    if (m_op == owbm_pkg::MODE_RD_BIT)
                        m_shift = {7'd0, level};
                    else
                        m_shift = {level, m_shift[7:1]};
                    m_phase = RD_REC;
                end
            RD_REC:
                if (tick_elapsed(t_cfg.read_recovery_time))
                    return finish_slot();
            WR_HOLD:
                if (tick_elapsed(t_cfg.write_hold_time))
                begin
                    m_low   = 1'b0;
                    m_shift = m_shift >> 1;
                    return finish_slot();
                end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // apply one accepted item to the model and return the status it produces
    function automatic bus_status_t advance_bus(input bus_item_t it);
        bus_status_t st;
        logic        done;
        logic        rej;
        logic [7:0]  rd;
        done = 1'b0;
        rej  = 1'b0;
        rd   = '0;
        if (it.mode == owbm_pkg::MODE_TICK)
        begin
            done = tick_bus(it.line_level);
            if (done && reading())
                rd = m_shift;
        end
        else if (it.mode <= owbm_pkg::MODE_RD_BIT)
        begin
            if (m_phase != BUS_IDLE)
                rej = 1'b1;
            else
            begin
                m_op    = it.mode;
                m_count = '0;
                case (it.mode)
                    owbm_pkg::MODE_RESET:
                    begin
                        m_low   = 1'b1;
                        m_phase = RST_LOW;
                    end
                    owbm_pkg::MODE_WR_BYTE:
                    begin
                        m_shift = it.data_byte;
                        m_bits  = BYTE_BITS;
                        start_slot();
                    end
                    owbm_pkg::MODE_WR_BIT:
                    begin
                        m_shift = {7'd0, it.data_byte[0]};
                        m_bits  = 4'd1;
                        start_slot();
                    end
                    owbm_pkg::MODE_RD_BYTE:
                    begin
                        m_shift = '0;
                        m_bits  = BYTE_BITS;
                        start_slot();
                    end
                    default:
                    begin
                        m_shift = '0;
                        m_bits  = 4'd1;
                        start_slot();
                    end
                endcase
            end
        end
        st.drive_low      = m_low;
        st.busy_res       = (m_phase != BUS_IDLE);
        st.done_res       = done;
        st.read_data      = rd;
        st.presence_level = m_presence;
        st.rejected       = rej;
        return st;
    endfunction

    function automatic string show_status(input bus_status_t s);
        return $sformatf("low=%b busy=%b done=%b data=%02h presence=%b rejected=%b",
                         s.drive_low, s.busy_res, s.done_res, s.read_data,
                         s.presence_level, s.rejected);
    endfunction

    // drive one item from a falling edge, hold it until the transfer happens
    task automatic push_item(input bus_item_t it, input bit typed, input bus_status_t want);
        bus_status_t st;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid      = 1'b1;
        item_ch.mode       = it.mode;
        item_ch.data_byte  = it.data_byte;
        item_ch.line_level = it.line_level;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        st = advance_bus(it);
        transfers_in++;
        if (st.rejected)
            commands_turned_away++;
        else if (it.mode != owbm_pkg::MODE_TICK && it.mode <= owbm_pkg::MODE_RD_BIT)
            ops_started++;
        pending_status.push_back(typed ? want : st);
        @(negedge clk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        item_ch.valid = 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [owbm_pkg::CIDX_W-1:0] idx,
                             input logic [owbm_pkg::CFG_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        case (idx)
            owbm_pkg::CFG_RESET_LOW:     t_cfg.reset_low_time      = val;
            owbm_pkg::CFG_PRESENCE_WAIT: t_cfg.presence_wait_time  = val;
            owbm_pkg::CFG_RESET_REC:     t_cfg.reset_recovery_time = val;
            owbm_pkg::CFG_SLOT_LOW:      t_cfg.slot_low_time       = val;
            owbm_pkg::CFG_READ_SAMPLE:   t_cfg.read_sample_time    = val;
            owbm_pkg::CFG_READ_REC:      t_cfg.read_recovery_time  = val;
            owbm_pkg::CFG_WRITE_HOLD:    t_cfg.write_hold_time     = val;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // timing sets: minimum, small random, defaults, zero, one register at max, moderate
    task automatic apply_setting(input int unsigned s);
        logic [owbm_pkg::CFG_W-1:0] vals [NUM_REGS];
        int unsigned                i;
        for (i = 0; i < NUM_REGS; i++)
        begin
            case (s)
                0:       vals[i] = 10'd1;
                1:       vals[i] = (owbm_pkg::CFG_W)'($urandom_range(0, 8));
                2:       vals[i] = REG_DEFAULTS[i];
                3:       vals[i] = 10'd0;
                4:       vals[i] = (owbm_pkg::CFG_W)'($urandom_range(0, 8));
                default: vals[i] = (owbm_pkg::CFG_W)'($urandom_range(1, 20));
            endcase
        end
        if (s == 4)
            vals[$urandom_range(0, NUM_REGS - 1)] = MAX_TICKS;
        for (i = 0; i < NUM_REGS; i++)
            write_reg(REG_ORDER[i], vals[i]);
    endtask

    function automatic logic [owbm_pkg::MODE_W-1:0] pick_command();
        case ($urandom_range(0, 4))
            0:       return owbm_pkg::MODE_RESET;
            1:       return owbm_pkg::MODE_WR_BYTE;
            2:       return owbm_pkg::MODE_RD_BYTE;
            3:       return owbm_pkg::MODE_WR_BIT;
            default: return owbm_pkg::MODE_RD_BIT;
        endcase
    endfunction

    // mostly complete commands with ticks until done, some noise and stray commands
    function automatic bus_item_t pick_item();
        bus_item_t   it;
        int unsigned roll;
        it.data_byte  = (owbm_pkg::DATA_W)'($urandom_range(0, 255));
        it.line_level = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (m_phase == BUS_IDLE)
        begin
            if (roll < 80)
                it.mode = pick_command();
            else if (roll < 90)
                it.mode = owbm_pkg::MODE_TICK;
            else
                it.mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
        end
        else
        begin
            if (roll < 92)
                it.mode = owbm_pkg::MODE_TICK;
            else if (roll < 97)
                it.mode = pick_command();
            else
                it.mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
        end
        return it;
    endfunction

    // an operation still running at the end carries over into the next timing set
    task automatic random_burst(input int unsigned budget);
        bus_item_t   it;
        int unsigned used;
        bit          ignored;
        used = 0;
        while (used < budget)
        begin
            it = pick_item();
            ignored = (m_phase == BUS_IDLE) &&
                      (it.mode == owbm_pkg::MODE_TICK || it.mode > owbm_pkg::MODE_RD_BIT);
            push_item(it, 1'b0, ST_NONE);
            if (!ignored)
                used++;
        end
    endtask

    // result side ready, changed on the falling edge
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready = ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // compare each result transfer with the oldest expected status
    always @(posedge clk)
    begin
        bus_status_t got;
        bus_status_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = '{result_ch.drive_low, result_ch.busy_res, result_ch.done_res,
                    result_ch.read_data, result_ch.presence_level, result_ch.rejected};
            results_checked++;
            if (pending_status.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT)
                    $display("cycle %0d: unexpected result %s", cycle_count, show_status(got));
            end
            else
            begin
                want = pending_status.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT)
                        $display("cycle %0d: expected %s, got %s", cycle_count,
                                 show_status(want), show_status(got));
                end
            end
        end
    end

    // stimulus
    initial
    begin
        bus_item_t   it;
        int unsigned r;
        int unsigned s;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = owbm_pkg::CFG_RESET_LOW;
        cfg_data           = '0;
        item_ch.valid      = 1'b0;
        item_ch.mode       = owbm_pkg::MODE_TICK;
        item_ch.data_byte  = '0;
        item_ch.line_level = 1'b1;
        reset_model();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (r = 0; r < PLAN_LEN; r++)
        begin
            if (PLAN[r].kind == ROW_REG)
            begin
                drain();
                write_reg(PLAN[r].reg_idx, PLAN[r].reg_val);
            end
            else
            begin
                it = '{PLAN[r].mode, PLAN[r].data_byte, PLAN[r].line_level};
                repeat (PLAN[r].reps) push_item(it, PLAN[r].typed, PLAN[r].want);
            end
        end

        // random traffic, two timing sets per idling pattern
        for (s = 0; s < NUM_SETTINGS; s++)
        begin
            if (s == 2)
            begin
                src_idle_pct = 80;
                snk_idle_pct = 22;
            end
            else if (s == 4)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            drain();
            apply_setting(s);
            random_burst(BURST_ITEMS);
        end

        drain();
        repeat (4) @(posedge clk);
        if (pending_status.size() != 0)
        begin
            mismatch_count++;
            $display("%0d expected results never arrived", pending_status.size());
        end
        $display("run covered %0d item transfers and %0d checked results over %0d cycles",
                 transfers_in, results_checked, cycle_count);
        $display("%0d bus commands started, %0d turned away while busy, %0d register writes",
                 ops_started, commands_turned_away, reg_writes);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
